// ===== rtl/fcs_pkg.sv =====
// Package for the farthest candidate selector.
// Holds the command and result word types and fixed constants; no dependencies.
package fcs_pkg;

  localparam int unsigned PointW  = 17;
  localparam int unsigned WindowW = 5;
  localparam int unsigned AddrW   = 2;
  localparam int unsigned DataW   = 32;

  localparam logic [WindowW-1:0] WindowRstVal = 5'd10;

  // Operation codes of a command word.
  localparam logic OpSeed      = 1'b0;
  localparam logic OpCandidate = 1'b1;

  typedef struct packed {
    logic              operation;
    logic [PointW-1:0] point;
    logic              last_candidate;
  } cmd_t;

  typedef struct packed {
    logic [PointW-1:0] chosen_point;
    logic [PointW-1:0] chosen_distance;
  } result_t;

endpackage

// ===== rtl/fcs_ring.sv =====
// History ring storage of the farthest candidate selector.
// One write port and one read port with registered read data; depends on nothing.
module fcs_ring #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 17
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/fcs_cfg.sv =====
// Configuration register file of the farthest candidate selector.
// APB-style slave holding the window size; uses fcs_pkg.
module fcs_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fcs_pkg::AddrW-1:0]       paddr,
  input  logic [fcs_pkg::DataW-1:0]       pwdata,
  output logic [fcs_pkg::DataW-1:0]       prdata,
  output logic                            pready,
  output logic [fcs_pkg::WindowW-1:0]     window_o
);

  logic [fcs_pkg::WindowW-1:0] window_q, window_d;
  logic                        wr_en;

  // The only register sits at byte address zero.
  assign wr_en = psel & penable & pwrite & (paddr == '0);

  always_comb begin
    window_d = window_q;
    if (wr_en) begin
      window_d = pwdata[fcs_pkg::WindowW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= fcs_pkg::WindowRstVal;
    end else begin
      window_q <= window_d;
    end
  end

  assign prdata   = {{(fcs_pkg::DataW - fcs_pkg::WindowW){1'b0}}, window_q};
  assign pready   = 1'b1;
  assign window_o = window_q;

endmodule

// ===== rtl/farthest_candidate_selector.sv =====
// Top level of the farthest candidate selector: command sequencer, scoring datapath.
// Instantiates fcs_ring and fcs_cfg; uses fcs_pkg.
//
// A seed word keeps busy low, so the next word may follow at once. A candidate word
// passes through StScan, StDrain and StFinish, or goes straight to StFinish when n is zero,
// where n is the smaller of window_in_use and the number of points held in the ring (at
// most HISTORY_DEPTH); in StScan the ring memory's single read port delivers one history
// entry per cycle. The last candidate of a set raises done_o for exactly one cycle with the
// winner and its distance, registered out of StFinish; results cannot be held off, so the
// receiver must take the word in that cycle. The window register may be written only
// while busy is low.
module farthest_candidate_selector #(
  parameter int unsigned HISTORY_DEPTH = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  fcs_pkg::cmd_t               cmd_i,
  output logic                        done_o,
  output fcs_pkg::result_t            result_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fcs_pkg::AddrW-1:0]   paddr,
  input  logic [fcs_pkg::DataW-1:0]   pwdata,
  output logic [fcs_pkg::DataW-1:0]   prdata,
  output logic                        pready
);

  localparam int unsigned AW   = $clog2(HISTORY_DEPTH);
  localparam int unsigned CntW = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned CmpW = (CntW > fcs_pkg::WindowW) ? CntW : fcs_pkg::WindowW;

  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StScan   = 4'b0010,
    StDrain  = 4'b0100,
    StFinish = 4'b1000
  } fsm_e;

  fsm_e                         state_q, state_d;
  logic [AW-1:0]                slot_q, slot_d;
  logic [CntW-1:0]              count_q, count_d;
  logic [AW-1:0]                rp_q, rp_d;
  logic [CntW-1:0]              rem_q, rem_d;
  logic                         rd_vld_q;
  logic [fcs_pkg::PointW-1:0]   min_q, min_d;
  logic [fcs_pkg::PointW-1:0]   pt_q, pt_d;
  logic                         last_q, last_d;
  logic [fcs_pkg::PointW-1:0]   best_pt_q, best_pt_d;
  logic [fcs_pkg::PointW-1:0]   best_dist_q, best_dist_d;
  logic                         have_q, have_d;
  logic                         done_q, done_d;
  fcs_pkg::result_t             result_q, result_d;

  logic [fcs_pkg::WindowW-1:0]  window;
  logic                         accept;
  logic [fcs_pkg::PointW-1:0]   in_pt;
  logic [CntW-1:0]              n_cmp;
  logic [AW-1:0]                newest;
  logic                         we, re;
  logic [AW-1:0]                waddr;
  logic [fcs_pkg::PointW-1:0]   wdata;
  logic [fcs_pkg::PointW-1:0]   rdata;
  logic [fcs_pkg::PointW-1:0]   diff;
  logic                         take;
  logic [fcs_pkg::PointW-1:0]   win_pt, win_dist;

  fcs_cfg u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .window_o (window)
  );

  fcs_ring #(
    .Depth (HISTORY_DEPTH),
    .Width (fcs_pkg::PointW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (rp_q),
    .rdata_o (rdata)
  );

  assign busy   = (state_q != StIdle);
  assign accept = start & ~busy;
  assign in_pt  = cmd_i.point;

  // Entries compared: the window, limited by how many points the ring holds.
  assign n_cmp = (CmpW'(window) < CmpW'(count_q)) ? CntW'(window) : count_q;
  assign newest = (slot_q == '0) ? AW'(HISTORY_DEPTH - 1) : slot_q - 1'b1;

  assign diff = (rdata >= pt_q) ? rdata - pt_q : pt_q - rdata;

  // A candidate replaces the running best only with a strictly greater score.
  assign take     = ~have_q | (min_q > best_dist_q);
  assign win_pt   = take ? pt_q  : best_pt_q;
  assign win_dist = take ? min_q : best_dist_q;

  assign re = (state_q == StScan);

  always_comb begin
    state_d     = state_q;
    slot_d      = slot_q;
    count_d     = count_q;
    rp_d        = rp_q;
    rem_d       = rem_q;
    min_d       = min_q;
    pt_d        = pt_q;
    last_d      = last_q;
    best_pt_d   = best_pt_q;
    best_dist_d = best_dist_q;
    have_d      = have_q;
    done_d      = 1'b0;
    result_d    = result_q;
    we          = 1'b0;
    waddr       = slot_q;
    wdata       = in_pt;

    if (rd_vld_q && diff < min_q) begin
      min_d = diff;
    end

    case (state_q)
      StIdle: begin
        if (accept) begin
          if (cmd_i.operation == fcs_pkg::OpSeed) begin
            we = 1'b1;
          end else begin
            pt_d   = in_pt;
            last_d = cmd_i.last_candidate;
            min_d  = '1;
            rp_d   = newest;
            rem_d  = n_cmp;
            state_d = (n_cmp == '0) ? StFinish : StScan;
          end
        end
      end
      StScan: begin
        rp_d  = (rp_q == '0) ? AW'(HISTORY_DEPTH - 1) : rp_q - 1'b1;
        rem_d = rem_q - 1'b1;
        if (rem_q == CntW'(1)) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        state_d = StFinish;
      end
      StFinish: begin
        state_d     = StIdle;
        best_pt_d   = win_pt;
        best_dist_d = win_dist;
        have_d      = 1'b1;
        if (last_q) begin
          we                       = 1'b1;
          wdata                    = win_pt;
          done_d                   = 1'b1;
          result_d.chosen_point    = win_pt;
          result_d.chosen_distance = win_dist;
          best_pt_d                = '0;
          best_dist_d              = '0;
          have_d                   = 1'b0;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    // Every ring write advances the slot and grows the fill up to the ring depth.
    if (we) begin
      slot_d = (slot_q == AW'(HISTORY_DEPTH - 1)) ? '0 : slot_q + 1'b1;
      if (count_q != CntW'(HISTORY_DEPTH)) begin
        count_d = count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      slot_q      <= '0;
      count_q     <= '0;
      rd_vld_q    <= 1'b0;
      best_pt_q   <= '0;
      best_dist_q <= '0;
      have_q      <= 1'b0;
      done_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      slot_q      <= slot_d;
      count_q     <= count_d;
      rd_vld_q    <= re;
      best_pt_q   <= best_pt_d;
      best_dist_q <= best_dist_d;
      have_q      <= have_d;
      done_q      <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rp_q     <= rp_d;
    rem_q    <= rem_d;
    min_q    <= min_d;
    pt_q     <= pt_d;
    last_q   <= last_d;
    result_q <= result_d;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

// ===== sim/fcs_choice_checker.sv =====
// Checker for the farthest candidate selector: watches the command, result and
// register ports, predicts each chosen word and compares it. Depends on fcs_pkg.
`timescale 1ns / 100ps

module fcs_choice_checker
  import fcs_pkg::*;
#(
  parameter logic [AddrW-1:0] WINDOW_ADDR = '0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  cmd_t              cmd_i,
  input  logic              done_i,
  input  result_t           result_i,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [AddrW-1:0]  paddr_i,
  input  logic [DataW-1:0]  pwdata_i,
  input  logic [DataW-1:0]  prdata_i,
  input  logic              pready_i,
  output int unsigned       pending_o,
  output int unsigned       fail_count_o
);

  localparam int unsigned HistDepth = 16;
  localparam logic [PointW-1:0] NoneCompared = '1;

  logic [PointW-1:0]  history [HistDepth];
  logic [4:0]         held_points;
  logic [3:0]         next_slot;
  logic [PointW-1:0]  lead_point;
  logic [PointW-1:0]  lead_gap;
  logic               lead_valid;
  logic [WindowW-1:0] window;
  result_t            awaited_choices [$];
  int unsigned        mismatches = 0;

  task automatic report(input string what, input logic [DataW-1:0] got,
                        input logic [DataW-1:0] want);
    $display("%0t ns: selector mismatch on %s: got %0h, want %0h", $time, what, got, want);
    mismatches++;
  endtask

  // The ring keeps the newest points; once full, the oldest is overwritten.
  task automatic remember_point(input logic [PointW-1:0] p);
    history[next_slot] = p;
    next_slot = next_slot + 4'd1;
    if (held_points < HistDepth) held_points = held_points + 5'd1;
  endtask

  // Stores a seed; scores a candidate against the newest points and keeps the running winner;
  // a last candidate closes the set and queues the chosen word.
  task automatic select_farthest(input cmd_t w);
    int unsigned        span;
    logic [PointW-1:0]  closest;
    logic [PointW-1:0]  gap;
    logic [PointW-1:0]  h;
    result_t            choice;
    if (w.operation == OpSeed) begin
      remember_point(w.point);
      return;
    end
    span = window;
    if (span > HistDepth) span = HistDepth;
    if (span > held_points) span = held_points;
    closest = NoneCompared;
    for (int k = 0; k < span; k++) begin
      h = history[4'(next_slot - 4'(k + 1))];
      gap = (h >= w.point) ? h - w.point : w.point - h;
      if (gap < closest) closest = gap;
    end
    // Only a strictly greater score displaces the running leader, so the first of a tie stays.
    if (!lead_valid || closest > lead_gap) begin
      lead_point = w.point;
      lead_gap = closest;
      lead_valid = 1'b1;
    end
    if (w.last_candidate) begin
      choice.chosen_point = lead_point;
      choice.chosen_distance = lead_gap;
      awaited_choices.insert(awaited_choices.size(), choice);
      remember_point(lead_point);
      lead_point = '0;
      lead_gap = '0;
      lead_valid = 1'b0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    result_t oldest;
    if (!rst_ni) begin
      for (int i = 0; i < HistDepth; i++) history[i] = '0;
      held_points = '0;
      next_slot = '0;
      lead_point = '0;
      lead_gap = '0;
      lead_valid = 1'b0;
      window = WindowRstVal;
      awaited_choices.delete();
      pending_o <= 0;
    end else begin
      if (done_i) begin
        if (awaited_choices.size() == 0) begin
          report("result word with no set closed", DataW'(result_i.chosen_point), '0);
        end else begin
          oldest = awaited_choices.pop_front();
          if (result_i.chosen_point !== oldest.chosen_point)
            report("chosen_point", DataW'(result_i.chosen_point), DataW'(oldest.chosen_point));
          if (result_i.chosen_distance !== oldest.chosen_distance)
            report("chosen_distance", DataW'(result_i.chosen_distance),
                   DataW'(oldest.chosen_distance));
        end
      end
      if (start_i && !busy_i) select_farthest(cmd_i);
      if (psel_i && penable_i && pready_i && paddr_i == WINDOW_ADDR) begin
        if (pwrite_i) begin
          window = pwdata_i[WindowW-1:0];
        end else if (prdata_i !== DataW'(window)) begin
          report("window read-back", prdata_i, DataW'(window));
        end
      end
      pending_o <= awaited_choices.size();
    end
    fail_count_o <= mismatches;
  end

endmodule

// ===== sim/tb_farthest_candidate_selector.sv =====
// Testbench top for the farthest candidate selector: drives command words and window writes
// with random gaps and gives the verdict. Needs fcs_pkg, the selector and fcs_choice_checker.
`timescale 1ns / 100ps

module tb_farthest_candidate_selector;
  import fcs_pkg::*;

  localparam logic [AddrW-1:0]  WindowAddr   = '0;
  localparam int unsigned       SettleCycles = 25;
  localparam int unsigned       IdleLimit    = 2000;
  localparam int unsigned       PhaseItems   = 85;
  localparam logic [PointW-1:0] PointMax     = '1;

  logic             clk_i   = 1'b0;
  logic             rst_ni  = 1'b0;
  logic             start   = 1'b0;
  logic             busy;
  cmd_t             cmd_w   = '0;
  logic             done_o;
  result_t          result_o;
  logic             psel    = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite  = 1'b0;
  logic [AddrW-1:0] paddr   = '0;
  logic [DataW-1:0] pwdata  = '0;
  logic [DataW-1:0] prdata;
  logic             pready;
  int unsigned      pending_results;
  int unsigned      mismatch_count;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  farthest_candidate_selector dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .cmd_i    (cmd_w),
    .done_o   (done_o),
    .result_o (result_o),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  fcs_choice_checker #(.WINDOW_ADDR(WindowAddr)) choice_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .cmd_i        (cmd_w),
    .done_i       (done_o),
    .result_i     (result_o),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .prdata_i     (prdata),
    .pready_i     (pready),
    .pending_o    (pending_results),
    .fail_count_o (mismatch_count)
  );

  // Mostly short gaps, now and then a long one; steady phases send back to back.
  task automatic idle_gap(input bit steady);
    int unsigned roll;
    int unsigned cycles;
    if (steady) return;
    roll = $urandom_range(0, 99);
    if (roll < 55) cycles = 0;
    else if (roll < 90) cycles = $urandom_range(1, 3);
    else cycles = $urandom_range(8, 40);
    if (cycles != 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Start stays high when the next word follows at once.
  task automatic issue(input logic op, input logic [PointW-1:0] p, input logic last,
                       input bit steady);
    idle_gap(steady);
    start <= 1'b1;
    cmd_w <= '{operation: op, point: p, last_candidate: last};
    do @(posedge clk_i); while (busy);
  endtask

  // Waits until every chosen word is in; with settle set, also lets a trailing
  // candidate that closes no set run out before the window is touched.
  task automatic drain(input bit settle);
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0 || busy) @(posedge clk_i);
    if (settle) repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [DataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= WindowAddr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  task automatic set_window(input logic [WindowW-1:0] value);
    drain(1'b1);
    apb_access(1'b1, DataW'(value));
    apb_access(1'b0, '0);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Clustered values give ties and zero scores; the rest cover every bit.
  function automatic logic [PointW-1:0] pick_point();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    case (roll)
      0:       return '0;
      1:       return PointMax;
      2, 3, 4: return PointW'($urandom_range(0, 31));
      5:       return PointMax - PointW'($urandom_range(0, 31));
      default: return PointW'($urandom());
    endcase
  endfunction

  // Mostly complete candidate sets, some with seeds mixed in; the rest is noise.
  task automatic random_phase(input int unsigned count, input bit steady, input bit hold_mid);
    int unsigned sent;
    int unsigned kind;
    int unsigned set_size;
    bit          held;
    sent = 0;
    held = 1'b0;
    while (sent < count) begin
      if (hold_mid && !held && sent >= count / 2) begin
        drain(1'b0);
        held = 1'b1;
      end
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        issue(OpSeed, pick_point(), 1'($urandom_range(0, 1)), steady);
        sent++;
      end else if (kind == 1) begin
        issue(OpCandidate, pick_point(), 1'($urandom_range(0, 1)), steady);
        sent++;
      end else begin
        repeat ($urandom_range(0, 2)) begin
          issue(OpSeed, pick_point(), 1'b0, steady);
          sent++;
        end
        set_size = $urandom_range(1, 6);
        for (int k = 1; k <= set_size; k++) begin
          if ($urandom_range(0, 7) == 0) begin
            issue(OpSeed, pick_point(), 1'b0, steady);
            sent++;
          end
          issue(OpCandidate, pick_point(), k == set_size, steady);
          sent++;
        end
      end
    end
  endtask

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IdleLimit) begin
      @(posedge clk_i);
      if ((start && !busy) || done_o || (psel && penable && pready)) quiet = 0;
      else quiet++;
    end
    $display("** farthest_candidate_selector: FAILED **");
    $finish;
  end

  initial begin : stimulus
    logic [WindowW-1:0] phase_window [10];
    phase_window = '{5'd16, 5'd2, 5'd31, 5'd0, 5'd17, 5'd1, 5'd10, 5'd0, 5'd0, 5'd15};
    phase_window[7] = WindowW'($urandom_range(0, 31));
    phase_window[8] = WindowW'($urandom_range(0, 31));

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The window register should read back its reset value.
    apb_access(1'b0, '0);
    psel    <= 1'b0;
    penable <= 1'b0;

    // Empty ring: both score all-ones, so the first of the tied pair wins.
    issue(OpCandidate, '0, 1'b0, 1'b0);
    issue(OpCandidate, PointMax, 1'b1, 1'b0);
    // A seed ignores its last flag and emits nothing.
    issue(OpSeed, PointMax, 1'b1, 1'b0);
    issue(OpCandidate, 17'd5, 1'b0, 1'b0);
    issue(OpCandidate, PointMax, 1'b0, 1'b0);
    issue(OpCandidate, 17'd65536, 1'b1, 1'b0);
    // Every candidate lands on a held point, so nothing scores above zero.
    issue(OpSeed, 17'd100, 1'b0, 1'b1);
    issue(OpSeed, 17'd200, 1'b0, 1'b1);
    issue(OpCandidate, 17'd200, 1'b0, 1'b1);
    issue(OpCandidate, 17'd100, 1'b1, 1'b1);
    // A seed in the middle of a set keeps the running best.
    issue(OpCandidate, 17'd7, 1'b0, 1'b0);
    issue(OpSeed, 17'd7, 1'b1, 1'b0);
    issue(OpCandidate, 17'd9, 1'b1, 1'b0);
    issue(OpCandidate, PointMax - 17'd1, 1'b1, 1'b0);
    set_window(5'd0);
    issue(OpCandidate, 17'd42, 1'b0, 1'b0);
    issue(OpCandidate, 17'd43, 1'b1, 1'b0);
    set_window(5'd31);
    issue(OpCandidate, 17'd50, 1'b1, 1'b0);
    set_window(5'd1);
    issue(OpCandidate, '0, 1'b1, 1'b0);

    for (int i = 0; i < 10; i++) begin
      set_window(phase_window[i]);
      random_phase(PhaseItems, i == 2 || i == 6, i == 4);
    end

    drain(1'b1);
    if (mismatch_count == 0) begin
      $display("** farthest_candidate_selector: PASSED **");
    end else begin
      $display("** farthest_candidate_selector: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/fcs_pkg.sv
rtl/fcs_ring.sv
rtl/fcs_cfg.sv
rtl/farthest_candidate_selector.sv
sim/fcs_choice_checker.sv
sim/tb_farthest_candidate_selector.sv
